[rtl/core/harmonic_fit_cost_accumulator_defines.svh]
// assertion macros shared by the cost accumulator rtl
`ifndef HARMONIC_FIT_COST_ACCUMULATOR_DEFINES_SVH
`define HARMONIC_FIT_COST_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTH
// plain invariant, checked on every rising clock edge out of reset
`define HFCA_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant violated");
// same-cycle implication
`define HFCA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication violated");
`else
`define HFCA_ASSERT(lbl, expr)
`define HFCA_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[rtl/core/hfca_pkg.sv]
// types, codes and constants of the harmonic fit cost accumulator
package hfca_pkg;

	typedef enum logic [4:0] {
		ST_IDLE, ST_START, ST_A2, ST_PHASE, ST_T, ST_T2, ST_HMUL, ST_HREC, ST_HFIX,
		ST_SFIN, ST_TRIG_END, ST_M2, ST_B2, ST_M3, ST_MODEL, ST_RESID, ST_SQ,
		ST_SLOPE, ST_DEN, ST_DIV, ST_ACC, ST_FIN
	} state_t;

	// request to the serial arithmetic unit
	typedef struct packed {
		logic        go;
		logic        div;
		logic [79:0] opa;
		logic [47:0] opb;
	} arith_req_t;

	typedef struct packed {
		logic        done;
		logic [79:0] res;
	} arith_rsp_t;

	localparam logic [2:0] MODE_PLAIN   = 3'd0;
	localparam logic [2:0] MODE_ERR     = 3'd1;
	localparam logic [2:0] MODE_PEARSON = 3'd2;
	localparam logic [2:0] MODE_TLS     = 3'd3;
	localparam logic [2:0] MODE_THREE   = 3'd4;

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_AMP    = 3'd1;
	localparam logic [2:0] REG_SECOND = 3'd2;
	localparam logic [2:0] REG_THIRD  = 3'd3;
	localparam logic [2:0] REG_WLOW   = 3'd4;
	localparam logic [2:0] REG_WHIGH  = 3'd5;

	localparam logic [62:0] SUM_MAX        = {63{1'b1}};
	localparam logic [30:0] ONE30          = 31'h4000_0000;
	localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
	localparam logic [31:0] TWO_PI_Q29     = 32'd3373259426;
	localparam logic [31:0] SQ_LIMIT       = 32'd3037000499;

	localparam int MUL_DIGITS = 8;
	localparam int DIV_BITS   = 80;

	// horner steps: sine uses 0..3, cosine 4..8
	localparam logic [3:0] HORNER_SIN_LAST = 4'd3;
	localparam logic [3:0] HORNER_LAST     = 4'd8;

	function automatic logic [6:0] horner_div(input logic [3:0] idx);
		logic [6:0] d;
		case (idx)
			4'd0: d = 7'd72;
			4'd1: d = 7'd42;
			4'd2: d = 7'd20;
			4'd3: d = 7'd6;
			4'd4: d = 7'd90;
			4'd5: d = 7'd56;
			4'd6: d = 7'd30;
			4'd7: d = 7'd12;
			4'd8: d = 7'd2;
			default: d = 7'd1;
		endcase
		return d;
	endfunction

	// floor(2^32 / divisor)
	function automatic logic [31:0] horner_recip(input logic [3:0] idx);
		logic [31:0] r;
		case (idx)
			4'd0: r = 32'd59652323;
			4'd1: r = 32'd102261126;
			4'd2: r = 32'd214748364;
			4'd3: r = 32'd715827882;
			4'd4: r = 32'd47721858;
			4'd5: r = 32'd76695844;
			4'd6: r = 32'd143165576;
			4'd7: r = 32'd357913941;
			4'd8: r = 32'd2147483648;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/hfca_arith.sv]
// shared serial unit: radix-16 multiplier and bit-serial restoring divider
module hfca_arith (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hfca_pkg::arith_req_t req,
	output hfca_pkg::arith_rsp_t rsp
);
	import hfca_pkg::*;

	logic        busy_q, div_q, done_q, ovf_q;
	logic [6:0]  cnt_q;
	logic [47:0] ma_q;
	logic [51:0] mh_q;
	logic [31:0] ml_q;
	logic [79:0] dn_q;
	logic [47:0] dd_q, rem_q;
	logic [63:0] quo_q;

	logic [51:0] pp;
	logic [52:0] msum;
	logic [48:0] trial;
	logic        ge;

	always_comb begin
		pp    = 52'(ma_q) * 52'(ml_q[3:0]);
		msum  = {1'b0, mh_q} + {1'b0, pp};
		trial = {rem_q, dn_q[79]};
		ge    = trial >= {1'b0, dd_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			div_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				div_q  <= req.div;
				cnt_q  <= req.div ? 7'(DIV_BITS - 1) : 7'(MUL_DIGITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			ma_q  <= req.opa[47:0];
			mh_q  <= '0;
			ml_q  <= req.opb[31:0];
			dn_q  <= req.opa;
			dd_q  <= req.opb;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			if (div_q) begin
				rem_q <= ge ? 48'(trial - {1'b0, dd_q}) : trial[47:0];
				quo_q <= {quo_q[62:0], ge};
				ovf_q <= ovf_q | quo_q[63];
				dn_q  <= {dn_q[78:0], 1'b0};
			end else begin
				// one multiplier digit a cycle, product shifts down into ml
				mh_q <= {3'b0, msum[52:4]};
				ml_q <= {msum[3:0], ml_q[31:4]};
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (div_q)
			rsp.res = (ovf_q | quo_q[63]) ? {17'b0, SUM_MAX} : {16'b0, quo_q};
		else
			rsp.res = {mh_q[47:0], ml_q};
	end

endmodule

[rtl/core/harmonic_fit_cost_accumulator.sv]
// harmonic fit cost accumulator: sequencer, datapath and result register
// throughput: one bin at a time, set by the shared serial unit
// reset: arst_n clears sums, count, flags, config registers and the output valid
`include "harmonic_fit_cost_accumulator_defines.svh"
module harmonic_fit_cost_accumulator #(
	parameter int MAX_BINS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // bin_center[15:0], bin_content[47:16], bin_sigma[71:48]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // cost_sum[62:0], bins_used[75:63], bad_divisor[76],
	                               // saturated[77], zero pad[79:78]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [22:0] cfg_wdata
);
	import hfca_pkg::*;

	localparam int CapInt = (MAX_BINS < 8191) ? MAX_BINS : 8191;
	localparam logic [12:0] COUNT_CAP = 13'(CapInt);

	state_t state_q, state_d;
	logic pend_q, cap;
	arith_req_t areq;
	arith_rsp_t arsp;

	logic [2:0]  mode_cfg_q;
	logic [14:0] amp_q;
	logic [22:0] bpar_q, coff_q;
	logic [15:0] wlo_q, whi_q;

	logic [15:0] x_q;
	logic [31:0] y_q;
	logic [23:0] err_q;
	logic        last_q, used_q;
	logic [2:0]  mode_q;

	logic        k3_q, dneg_q;
	logic [1:0]  quad_q;
	logic [29:0] tmag_q, t_q, t2_q;
	logic [30:0] acc_q, w_q, q0_q, sin_q;
	logic [3:0]  idx_q;

	logic [29:0] a2_q;
	logic [17:0] c2_q, s2_q, c3_q;
	logic [44:0] b2_q;
	logic [41:0] m2_q, m3_q, m_q, rmag_q;
	logic [63:0] sq_q;
	logic [23:0] dm_q;
	logic [47:0] den_q;
	logic [62:0] term_q;

	logic [62:0] cost_q;
	logic [12:0] count_q;
	logic        fault_q, sat_q;
	logic        m_tvalid_q;
	logic [79:0] m_tdata_q;

	// combinational datapath
	logic        in_fire, out_load, inside_lo, inside_hi;
	logic [17:0] x18, kx, kmag;
	logic        kneg;
	logic [47:0] p48;
	logic [31:0] u;
	logic [6:0]  hd;
	logic [37:0] qd, hrem;
	logic [30:0] qc, acc_new;
	logic [32:0] s_sgn, c_sgn, co_w, si_w, co_sh, si_sh;
	logic [17:0] co16, si16, c2mag, c3mag, s2mag;
	logic [22:0] bmag;
	logic [48:0] v49, vr49;
	logic [63:0] v64, vr64;
	logic [49:0] v50, vr50;
	logic [25:0] dydx;
	logic [41:0] m_new;
	logic [42:0] r43;
	logic [41:0] rmag;
	logic        skip, big;
	logic [63:0] sum64;
	logic [79:0] div_num;

	assign in_fire  = s_tvalid && s_tready;
	assign cap      = pend_q && arsp.done;
	assign out_load = (state_q == ST_FIN) && last_q && (!m_tvalid_q || m_tready);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign inside_lo = $signed(s_tdata[15:0]) <= $signed(wlo_q);
	assign inside_hi = $signed(s_tdata[15:0]) >= $signed(whi_q);

	always_comb begin
		// phase of k*x
		x18  = {{2{x_q[15]}}, x_q};
		kx   = k3_q ? x18 + {x18[16:0], 1'b0} : {x18[16:0], 1'b0};
		kneg = kx[17];
		kmag = kneg ? 18'(18'd0 - kx) : kx;
		p48  = kneg ? 48'(48'd0 - arsp.res[47:0]) : arsp.res[47:0];
		u    = p48[43:12] + 32'h2000_0000;

		// one horner step: exact division by a small constant
		hd      = horner_div(idx_q);
		qd      = 38'(q0_q) * 38'(hd);
		hrem    = 38'(w_q) - qd;
		qc      = (hrem >= 38'(hd)) ? q0_q + 31'd1 : q0_q;
		acc_new = ONE30 - qc;

		// quadrant rotation and rounding to q16
		s_sgn = dneg_q ? 33'd0 - {2'b0, sin_q} : {2'b0, sin_q};
		c_sgn = {2'b0, acc_q};
		case (quad_q)
			2'd0: begin co_w = c_sgn; si_w = s_sgn; end
			2'd1: begin co_w = 33'd0 - s_sgn; si_w = c_sgn; end
			2'd2: begin co_w = 33'd0 - c_sgn; si_w = 33'd0 - s_sgn; end
			default: begin co_w = s_sgn; si_w = 33'd0 - c_sgn; end
		endcase
		co_sh = co_w + 33'd8192;
		si_sh = si_w + 33'd8192;
		co16  = co_sh[31:14];
		si16  = si_sh[31:14];

		c2mag = c2_q[17] ? 18'(18'd0 - c2_q) : c2_q;
		c3mag = c3_q[17] ? 18'(18'd0 - c3_q) : c3_q;
		s2mag = s2_q[17] ? 18'(18'd0 - s2_q) : s2_q;
		bmag  = bpar_q[22] ? 23'(23'd0 - bpar_q) : bpar_q;

		// a^2 * cos 2x, rounded to q8
		v49  = c2_q[17] ? 49'd0 - {2'b0, arsp.res[46:0]} : {2'b0, arsp.res[46:0]};
		vr49 = v49 + 49'd8388608;
		// b^2 * cos 3x, rounded to q8
		v64  = c3_q[17] ? 64'd0 - {2'b0, arsp.res[61:0]} : {2'b0, arsp.res[61:0]};
		vr64 = v64 + 64'd8388608;
		// slope -2 a^2 sin 2x, rounded to q8
		v50  = s2_q[17] ? {1'b0, arsp.res[46:0], 1'b0, 1'b0} >> 1
			: 50'd0 - ({1'b0, arsp.res[46:0], 2'b0} >> 1);
		vr50 = v50 + 50'd8388608;
		dydx = vr50[49:24];

		m_new = m2_q + ((mode_q == MODE_THREE)
			? m3_q + {{19{coff_q[22]}}, coff_q}
			: {{19{bpar_q[22]}}, bpar_q});
		r43  = {m_q[41], m_q} - {{11{y_q[31]}}, y_q};
		rmag = r43[42] ? 42'(43'd0 - r43) : r43[41:0];
		skip = ((mode_q == MODE_ERR) && (err_q == '0))
			|| ((mode_q == MODE_PEARSON) && ($signed(m_q) <= 0));
		big  = rmag > 42'(SQ_LIMIT);

		sum64   = {1'b0, cost_q} + {1'b0, term_q};
		div_num = (mode_q == MODE_PEARSON) ? {8'b0, sq_q, 8'b0} : {sq_q, 16'b0};
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (s_tvalid) state_d = ST_START;
			ST_START:    state_d = used_q ? ST_A2 : ST_FIN;
			ST_A2:       if (cap) state_d = ST_PHASE;
			ST_PHASE:    if (cap) state_d = ST_T;
			ST_T:        if (cap) state_d = ST_T2;
			ST_T2:       if (cap) state_d = ST_HMUL;
			ST_HMUL:     if (cap) state_d = ST_HREC;
			ST_HREC:     if (cap) state_d = ST_HFIX;
			ST_HFIX: begin
				if (idx_q == HORNER_SIN_LAST)
					state_d = ST_SFIN;
				else if (idx_q == HORNER_LAST)
					state_d = ST_TRIG_END;
				else
					state_d = ST_HMUL;
			end
			ST_SFIN:     if (cap) state_d = ST_HMUL;
			ST_TRIG_END: state_d = k3_q ? ST_M3 : ST_M2;
			ST_M2:       if (cap) state_d = (mode_q == MODE_THREE) ? ST_B2 : ST_MODEL;
			ST_B2:       if (cap) state_d = ST_PHASE;
			ST_M3:       if (cap) state_d = ST_MODEL;
			ST_MODEL:    state_d = ST_RESID;
			ST_RESID: begin
				if (skip)
					state_d = ST_FIN;
				else if (big)
					state_d = ST_ACC;
				else
					state_d = ST_SQ;
			end
			ST_SQ: begin
				if (cap) begin
					case (mode_q)
						MODE_ERR:     state_d = ST_DEN;
						MODE_PEARSON: state_d = ST_DIV;
						MODE_TLS:     state_d = ST_SLOPE;
						default:      state_d = ST_ACC;
					endcase
				end
			end
			ST_SLOPE:    if (cap) state_d = ST_DEN;
			ST_DEN:      if (cap) state_d = ST_DIV;
			ST_DIV:      if (cap) state_d = ST_ACC;
			ST_ACC:      state_d = ST_FIN;
			ST_FIN:      if (!last_q || out_load) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// requests to the serial unit
	always_comb begin
		areq.go  = 1'b0;
		areq.div = 1'b0;
		areq.opa = '0;
		areq.opb = '0;
		case (state_q)
			ST_A2:    begin areq.opa = 80'(amp_q); areq.opb = 48'(amp_q); end
			ST_PHASE: begin areq.opa = 80'(kmag); areq.opb = 48'(INV_TWO_PI_Q32); end
			ST_T:     begin areq.opa = 80'(tmag_q); areq.opb = 48'(TWO_PI_Q29); end
			ST_T2:    begin areq.opa = 80'(t_q); areq.opb = 48'(t_q); end
			ST_HMUL:  begin areq.opa = 80'(t2_q); areq.opb = 48'(acc_q); end
			ST_HREC:  begin areq.opa = 80'(w_q); areq.opb = 48'(horner_recip(idx_q)); end
			ST_SFIN:  begin areq.opa = 80'(t_q); areq.opb = 48'(acc_q); end
			ST_M2:    begin areq.opa = 80'(a2_q); areq.opb = 48'(c2mag); end
			ST_B2:    begin areq.opa = 80'(bmag); areq.opb = 48'(bmag); end
			ST_M3:    begin areq.opa = 80'(b2_q); areq.opb = 48'(c3mag); end
			ST_SQ:    begin areq.opa = 80'(rmag_q); areq.opb = 48'(rmag_q[31:0]); end
			ST_SLOPE: begin areq.opa = 80'(a2_q); areq.opb = 48'(s2mag); end
			ST_DEN: begin
				if (mode_q == MODE_ERR) begin
					areq.opa = 80'(err_q);
					areq.opb = 48'(err_q);
				end else begin
					areq.opa = 80'(dm_q);
					areq.opb = 48'(dm_q);
				end
			end
			ST_DIV: begin
				areq.div = 1'b1;
				areq.opa = div_num;
				areq.opb = (mode_q == MODE_PEARSON) ? 48'(m_q[40:0]) : den_q;
			end
			default: ;
		endcase
		case (state_q)
			ST_A2, ST_PHASE, ST_T, ST_T2, ST_HMUL, ST_HREC, ST_SFIN, ST_M2, ST_B2,
			ST_M3, ST_SQ, ST_SLOPE, ST_DEN, ST_DIV: areq.go = !pend_q;
			default: areq.go = 1'b0;
		endcase
	end

	hfca_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (areq),
		.rsp    (arsp)
	);

	// control and accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_q     <= 1'b0;
			k3_q       <= 1'b0;
			idx_q      <= '0;
			mode_cfg_q <= '0;
			amp_q      <= '0;
			bpar_q     <= '0;
			coff_q     <= '0;
			wlo_q      <= '0;
			whi_q      <= '0;
			cost_q     <= '0;
			count_q    <= '0;
			fault_q    <= 1'b0;
			sat_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (areq.go)
				pend_q <= 1'b1;
			else if (cap)
				pend_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_addr)
					REG_MODE:   mode_cfg_q <= cfg_wdata[2:0];
					REG_AMP:    amp_q      <= cfg_wdata[14:0];
					REG_SECOND: bpar_q     <= cfg_wdata;
					REG_THIRD:  coff_q     <= cfg_wdata;
					REG_WLOW:   wlo_q      <= cfg_wdata[15:0];
					REG_WHIGH:  whi_q      <= cfg_wdata[15:0];
					default: ;
				endcase
			end

			if (state_q == ST_START)
				k3_q <= 1'b0;
			if (state_q == ST_B2 && cap)
				k3_q <= 1'b1;
			if (state_q == ST_T2 && cap)
				idx_q <= '0;
			if (state_q == ST_HFIX)
				idx_q <= idx_q + 4'd1;

			if (state_q == ST_RESID && skip)
				fault_q <= 1'b1;

			if (state_q == ST_ACC) begin
				if (sum64 >= {1'b0, SUM_MAX}) begin
					cost_q <= SUM_MAX;
					sat_q  <= 1'b1;
				end else begin
					cost_q <= sum64[62:0];
				end
				if (count_q < COUNT_CAP)
					count_q <= count_q + 13'd1;
			end

			if (out_load) begin
				m_tvalid_q <= 1'b1;
				cost_q     <= '0;
				count_q    <= '0;
				fault_q    <= 1'b0;
				sat_q      <= 1'b0;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q    <= s_tdata[15:0];
			y_q    <= s_tdata[47:16];
			err_q  <= s_tdata[71:48];
			last_q <= s_tlast;
			used_q <= inside_lo || inside_hi;
			mode_q <= (mode_cfg_q > MODE_THREE) ? MODE_PLAIN : mode_cfg_q;
		end
		if (out_load)
			m_tdata_q <= {2'b0, sat_q, fault_q, count_q, cost_q};
		case (state_q)
			ST_A2:    if (cap) a2_q <= arsp.res[29:0];
			ST_PHASE: begin
				if (cap) begin
					quad_q <= u[31:30];
					dneg_q <= ~u[29];
					tmag_q <= u[29] ? {1'b0, u[28:0]} : 30'h2000_0000 - {1'b0, u[28:0]};
				end
			end
			ST_T:     if (cap) t_q <= arsp.res[60:31];
			ST_T2: begin
				if (cap) begin
					t2_q  <= arsp.res[59:30];
					acc_q <= ONE30;
				end
			end
			ST_HMUL:  if (cap) w_q <= arsp.res[60:30];
			ST_HREC:  if (cap) q0_q <= arsp.res[62:32];
			ST_HFIX:  acc_q <= acc_new;
			ST_SFIN: begin
				if (cap) begin
					sin_q <= arsp.res[60:30];
					acc_q <= ONE30;
				end
			end
			ST_TRIG_END: begin
				if (k3_q) begin
					c3_q <= co16;
				end else begin
					c2_q <= co16;
					s2_q <= si16;
				end
			end
			ST_M2:    if (cap) m2_q <= {{17{vr49[48]}}, vr49[48:24]};
			ST_B2:    if (cap) b2_q <= arsp.res[44:0];
			ST_M3:    if (cap) m3_q <= {{2{vr64[63]}}, vr64[63:24]};
			ST_MODEL: m_q <= m_new;
			ST_RESID: begin
				rmag_q <= rmag;
				term_q <= SUM_MAX;
			end
			ST_SQ: begin
				if (cap) begin
					sq_q   <= arsp.res[63:0];
					term_q <= arsp.res[62:0];
				end
			end
			ST_SLOPE: if (cap) dm_q <= dydx[25] ? 24'(26'd0 - dydx) : dydx[23:0];
			ST_DEN: begin
				if (cap)
					den_q <= (mode_q == MODE_TLS) ? arsp.res[47:0] + 48'h1_0000
						: arsp.res[47:0];
			end
			ST_DIV:   if (cap) term_q <= arsp.res[62:0];
			default: ;
		endcase
	end

	`HFCA_ASSERT(a_count_cap, count_q <= COUNT_CAP)
	`HFCA_ASSERT_IMP(a_sat_pins_sum, sat_q, cost_q == SUM_MAX)
	`HFCA_ASSERT_IMP(a_done_only_pending, arsp.done, pend_q)
	`HFCA_ASSERT_IMP(a_word_from_fin, $rose(m_tvalid_q), $past(state_q) == ST_FIN)

endmodule
